// ===== hw/rtl/npps_pkg.sv =====
// ----------------------------------------------------------------------------
// npps_pkg: shared constants and helpers
// Sizes of the position space, the count store and the occupancy bitmap,
// plus the bit search functions used by the serve path.
// ----------------------------------------------------------------------------
package npps_pkg;

  localparam int POSITIONS   = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam int PW          = $clog2(POSITIONS);   // position width
  localparam int BMW         = 32;                  // bitmap word width
  localparam int BW          = $clog2(BMW);         // bit index width
  localparam int WORDS       = POSITIONS / BMW;     // bitmap words
  localparam int WAW         = PW - BW;             // word index width
  localparam int SUM_WIDTH   = 48;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_SERVE = 1'b1;

  // highest set bit of a bitmap word
  function automatic logic [BW-1:0] word_hi(input logic [BMW-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = 0; i < BMW; i++) begin
      if (v[i]) r = BW'(i);
    end
    return r;
  endfunction

  // lowest set bit of a bitmap word
  function automatic logic [BW-1:0] word_lo(input logic [BMW-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = BMW - 1; i >= 0; i--) begin
      if (v[i]) r = BW'(i);
    end
    return r;
  endfunction

  // highest set bit of the word summary
  function automatic logic [WAW-1:0] sum_hi(input logic [WORDS-1:0] v);
    logic [WAW-1:0] r;
    r = '0;
    for (int i = 0; i < WORDS; i++) begin
      if (v[i]) r = WAW'(i);
    end
    return r;
  endfunction

  // lowest set bit of the word summary
  function automatic logic [WAW-1:0] sum_lo(input logic [WORDS-1:0] v);
    logic [WAW-1:0] r;
    r = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WAW'(i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/npps_ram.sv =====
// ----------------------------------------------------------------------------
// npps_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module npps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/nearest_pending_position_server_core.sv =====
// ----------------------------------------------------------------------------
// nearest_pending_position_server_core: nearest pending request server
// Keeps per-position request counts and serves the one nearest the head.
// ----------------------------------------------------------------------------
// Counts live in a 1024 x 16 RAM; a 32 x 32 occupancy bitmap RAM marks the
// positions with a nonzero count, and a 32-bit register marks the bitmap
// words that are nonzero. After reset a clearing pass over all POSITIONS
// (1024) addresses zeroes both RAMs; no input word is taken during it. An
// add reads the count and bitmap word, writes back, then gives the result;
// a serve reads the head's bitmap word, reads the nearest nonzero word
// below and above, reads the picked count and bitmap word, writes back,
// then gives the result (the write back is skipped when nothing is
// pending). Each result sits in the output register until taken; the
// next input word is accepted the cycle after the result leaves. Ties in
// distance follow the last nonzero move, upward at start.
module nearest_pending_position_server_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [9:0]                    position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          served,
  output logic [9:0]                    served_position,
  output logic [9:0]                    moved_distance,
  output logic [47:0]                   total_distance,
  output logic                          count_overflow
);
  import npps_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_WB, S_W0, S_LO, S_HI, S_PICK, S_S_WB, S_OUT
  } state_t;

  state_t              state;
  logic [PW:0]         clr_addr;
  logic [PW-1:0]       head;
  logic [1:0]          dir;
  logic [SUM_WIDTH-1:0] sum;
  logic [WORDS-1:0]    summary;
  logic [PW-1:0]       lo, hi, pick, req_pos;
  logic                have_lo, have_hi;

  // RAM ports
  logic                   cnt_we, bm_we;
  logic [PW-1:0]          cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic [WAW-1:0]         bm_waddr, bm_raddr;
  logic [BMW-1:0]         bm_wdata, bm_rdata;

  npps_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(POSITIONS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  npps_ram #(.WIDTH(BMW), .DEPTH(WORDS)) u_bm (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  // head split into bitmap word and bit
  logic [WAW-1:0] hw;
  logic [BW-1:0]  hb;
  assign hw = head[PW-1:BW];
  assign hb = head[BW-1:0];

  // summary words strictly below / above the head's word
  logic [WORDS-1:0] sum_below, sum_above;
  always_comb begin
    for (int i = 0; i < WORDS; i++) begin
      sum_below[i] = summary[i] && (WAW'(i) < hw);
      sum_above[i] = summary[i] && (WAW'(i) > hw);
    end
  end

  // bits of the head word at or below / at or above the head
  logic [BMW-1:0] w_lo_m, w_hi_m;
  always_comb begin
    for (int i = 0; i < BMW; i++) begin
      w_lo_m[i] = bm_rdata[i] && (BW'(i) <= hb);
      w_hi_m[i] = bm_rdata[i] && (BW'(i) >= hb);
    end
  end

  // pick: nearest, ties go low after a downward last move, else high
  logic [PW-1:0] dl, dh, pick_c;
  always_comb begin
    dl = head - lo;
    dh = hi - head;
    if (!have_hi)                 pick_c = lo;
    else if (!have_lo)            pick_c = hi;
    else if (dl < dh)             pick_c = lo;
    else if (dh < dl)             pick_c = hi;
    else if (dir == DIR_DOWN)     pick_c = lo;
    else                          pick_c = hi;
  end

  // write-back values
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [BMW-1:0]         bm_clr, bm_set;
  logic [PW-1:0]          move_len;
  logic [SUM_WIDTH:0]     sum_add;
  assign cnt_dec = cnt_rdata - 1'b1;
  assign bm_clr  = (cnt_dec == '0) ? (bm_rdata & ~(BMW'(1) << pick[BW-1:0])) : bm_rdata;
  assign bm_set  = bm_rdata | (BMW'(1) << req_pos[BW-1:0]);
  assign move_len = (pick >= head) ? (pick - head) : (head - pick);
  assign sum_add = {1'b0, sum} + {{(SUM_WIDTH + 1 - PW){1'b0}}, move_len};

  // RAM control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = req_pos;
    cnt_wdata = cnt_rdata + 1'b1;
    cnt_raddr = position;
    bm_we     = 1'b0;
    bm_waddr  = req_pos[PW-1:BW];
    bm_wdata  = bm_set;
    bm_raddr  = position[PW-1:BW];
    case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr[PW-1:0];
        cnt_wdata = '0;
        bm_we     = (clr_addr < (PW+1)'(WORDS));
        bm_waddr  = clr_addr[WAW-1:0];
        bm_wdata  = '0;
      end
      S_IDLE: begin
        if (func == FUNC_SERVE) bm_raddr = hw;
      end
      S_A_WB: begin
        if (cnt_rdata != COUNT_MAX) begin
          cnt_we = 1'b1;
          bm_we  = 1'b1;
        end
      end
      S_W0:   bm_raddr = sum_hi(sum_below);
      S_LO:   bm_raddr = sum_lo(sum_above);
      S_PICK: begin
        cnt_raddr = pick_c;
        bm_raddr  = pick_c[PW-1:BW];
      end
      S_S_WB: begin
        cnt_we    = 1'b1;
        cnt_waddr = pick;
        cnt_wdata = cnt_dec;
        bm_we     = 1'b1;
        bm_waddr  = pick[PW-1:BW];
        bm_wdata  = bm_clr;
      end
      default: ;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      head           <= '0;
      dir            <= DIR_NONE;
      sum            <= '0;
      summary        <= '0;
      served         <= 1'b0;
      served_position <= '0;
      moved_distance <= '0;
      total_distance <= '0;
      count_overflow <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (PW+1)'(POSITIONS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_pos         <= position;
            served          <= 1'b0;
            served_position <= '0;
            moved_distance  <= '0;
            total_distance  <= sum;
            count_overflow  <= 1'b0;
            if (func == FUNC_SERVE)            state <= S_W0;
            else if (32'(position) < POSITIONS) state <= S_A_WB;
            else                               state <= S_OUT;
          end
        end
        S_A_WB: begin
          if (cnt_rdata == COUNT_MAX) count_overflow <= 1'b1;
          else summary[req_pos[PW-1:BW]] <= 1'b1;
          state <= S_OUT;
        end
        S_W0: begin
          have_lo <= |w_lo_m;
          have_hi <= |w_hi_m;
          lo      <= {hw, word_hi(w_lo_m)};
          hi      <= {hw, word_lo(w_hi_m)};
          state   <= S_LO;
        end
        S_LO: begin
          if (!have_lo && (|sum_below)) begin
            have_lo <= 1'b1;
            lo      <= {sum_hi(sum_below), word_hi(bm_rdata)};
          end
          state <= S_HI;
        end
        S_HI: begin
          if (!have_hi && (|sum_above)) begin
            have_hi <= 1'b1;
            hi      <= {sum_lo(sum_above), word_lo(bm_rdata)};
          end
          state <= S_PICK;
        end
        S_PICK: begin
          pick  <= pick_c;
          state <= (have_lo || have_hi) ? S_S_WB : S_OUT;
        end
        S_S_WB: begin
          summary[pick[PW-1:BW]] <= |bm_clr;
          if (pick > head)      dir <= DIR_UP;
          else if (pick < head) dir <= DIR_DOWN;
          head <= pick;
          sum  <= sum_add[SUM_WIDTH] ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
          served          <= 1'b1;
          served_position <= pick;
          moved_distance  <= move_len;
          total_distance  <= sum_add[SUM_WIDTH] ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
